### hw/rtl/ltd_pkg.sv
// Shared types, codes and reset constants for the line-trace drive block.
// No dependencies; imported by ltd_marks and line_trace_drive_with_color_marks.
`timescale 1ns / 1ps
`default_nettype none

package ltd_pkg;

    localparam int DEF_MARK_DEPTH = 10;
    localparam int MIN_SEQ_LEN    = 3;

    localparam logic signed [15:0] SEEK_LIMIT = -16'sd1280;

    localparam logic signed [15:0] RST_PROP_GAIN  = 16'sd256;
    localparam logic signed [15:0] RST_DERIV_GAIN = 16'sd0;
    localparam logic signed [15:0] RST_BASE_SPEED = 16'sd77;
    localparam logic signed [15:0] RST_MAX_SPEED  = 16'sd256;
    localparam logic signed [15:0] RST_MIN_SPEED  = 16'sd0;
    localparam logic [3:0]         RST_WHITE_CODE = 4'd0;
    localparam logic [3:0]         RST_BLACK_CODE = 4'd1;
    localparam logic [7:0]         RST_MARK_THR   = 8'd10;

    localparam logic [3:0] MARK_THREE = 4'd3;
    localparam logic [3:0] MARK_FOUR  = 4'd4;
    localparam logic [3:0] MARK_FIVE  = 4'd5;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SLOW = 2'd1,
        CMD_FAST = 2'd2,
        CMD_REV  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_DERIV_GAIN = 3'd1,
        CFG_BASE_SPEED = 3'd2,
        CFG_MAX_SPEED  = 3'd3,
        CFG_MIN_SPEED  = 3'd4,
        CFG_WHITE_CODE = 3'd5,
        CFG_BLACK_CODE = 3'd6,
        CFG_MARK_THR   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0] white_code;
        logic [3:0] black_code;
        logic [7:0] threshold;
    } t_mark_cfg;

    typedef struct packed {
        t_cmd cmd;
        logic rev;
    } t_mark_res;

    // when the limits cross, values above hi take hi and all others take lo
    function automatic logic signed [15:0] f_clamp(
        input logic signed [26:0] v,
        input logic signed [15:0] hi,
        input logic signed [15:0] lo
    );
        logic signed [15:0] r;
        if (v > 27'(hi)) begin
            r = hi;
        end else if (v < 27'(lo)) begin
            r = lo;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] f_negsat(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == -16'sd32768) begin
            r = 16'sd32767;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/line_trace_drive_with_color_marks.sv
// Line-trace drive top level: config registers, step stage, PD speed law, output word.
// Depends on ltd_pkg and ltd_marks.
//
// Usage:
//   Sensor words enter on the s-side stream (tdata = line_position, color_code).
//   One result word per sample leaves on the m-side stream
//   (tdata = left_speed, right_speed, mark_command).
//   Registers are written over the cfg channel (index 0..7), always ready;
//   write them only while no sample is in flight.
// Order: an accepted sample is registered in the step stage, then its result word in
//   the output stage once that stage is empty or the receiver takes its word.
// Throughput: one sample per cycle unless the output stalls; the step stage does the
//   debounce, mark match, one Q8.8 multiply per product, add and clamp combinationally.
// Reset (synchronous, active low): registers take their default values, the
//   mark state and previous position clear, direction returns to forward, and
//   both stream stages empty.
// Stall: a held result word keeps its data; the step stage holds one more
//   sample, after which s-side tready drops until the receiver takes a word.
`timescale 1ns / 1ps
`default_nettype none

module line_trace_drive_with_color_marks import ltd_pkg::*; #(
    parameter int MARK_DEPTH = DEF_MARK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [15:0] line_position, [19:16] color_code
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [15:0] left_speed, [31:16] right_speed,
                                          // [33:32] mark_command
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic signed [15:0] r_prop;
    logic signed [15:0] r_deriv;
    logic signed [15:0] r_base;
    logic signed [15:0] r_max;
    logic signed [15:0] r_min;
    logic [3:0]         r_white;
    logic [3:0]         r_black;
    logic [7:0]         r_thr;

    logic               r_s1_valid;
    logic signed [15:0] r_s1_line;
    logic [3:0]         r_s1_color;
    logic signed [15:0] r_prev;

    logic               r_out_valid;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    t_cmd               r_cmd;

    logic               w_adv;
    t_mark_cfg          w_mark_cfg;
    t_mark_res          w_mark_res;

    logic signed [31:0] w_prod_p;
    logic signed [16:0] w_d;
    logic signed [32:0] w_prod_d;
    logic signed [23:0] w_pq;
    logic signed [24:0] w_dq;
    logic signed [26:0] w_vl;
    logic signed [26:0] w_vr;
    logic signed [15:0] w_cl;
    logic signed [15:0] w_cr;
    logic signed [15:0] n_left;
    logic signed [15:0] n_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop  <= RST_PROP_GAIN;
            r_deriv <= RST_DERIV_GAIN;
            r_base  <= RST_BASE_SPEED;
            r_max   <= RST_MAX_SPEED;
            r_min   <= RST_MIN_SPEED;
            r_white <= RST_WHITE_CODE;
            r_black <= RST_BLACK_CODE;
            r_thr   <= RST_MARK_THR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_prop  <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv <= i_cfg_data;
                CFG_BASE_SPEED: r_base  <= i_cfg_data;
                CFG_MAX_SPEED:  r_max   <= i_cfg_data;
                CFG_MIN_SPEED:  r_min   <= i_cfg_data;
                CFG_WHITE_CODE: r_white <= i_cfg_data[3:0];
                CFG_BLACK_CODE: r_black <= i_cfg_data[3:0];
                CFG_MARK_THR:   r_thr   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_s1_line  <= i_s_tdata[15:0];
            r_s1_color <= i_s_tdata[19:16];
        end
    end

    assign w_mark_cfg.white_code = r_white;
    assign w_mark_cfg.black_code = r_black;
    assign w_mark_cfg.threshold  = r_thr;

    ltd_marks #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_marks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_color (r_s1_color),
        .i_cfg   (w_mark_cfg),
        .o_res   (w_mark_res)
    );

    always_comb begin
        w_prod_p = 32'(r_prop) * 32'(r_s1_line);
        w_d      = 17'(r_s1_line) - 17'(r_prev);
        w_prod_d = 33'(w_d) * 33'(r_deriv);
        w_pq     = $signed(w_prod_p[31:8]);
        w_dq     = $signed(w_prod_d[32:8]);

        w_vl = 27'(r_base);
        w_vr = 27'(r_base);
        if (!(r_s1_line < SEEK_LIMIT)) begin
            if (r_s1_line > 16'sd0) begin
                w_vr = 27'(r_base) - 27'(w_pq);
            end else if (r_s1_line < 16'sd0) begin
                w_vl = 27'(r_base) + 27'(w_pq);
            end
        end
        w_vl = w_vl + 27'(w_dq);
        w_vr = w_vr + 27'(w_dq);

        w_cl = f_clamp(w_vl, r_max, r_min);
        w_cr = f_clamp(w_vr, r_max, r_min);

        if (w_mark_res.rev) begin
            n_left  = f_negsat(w_cr);
            n_right = f_negsat(w_cl);
        end else begin
            n_left  = w_cl;
            n_right = w_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 16'sd0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_prev      <= r_s1_line;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_cmd   <= w_mark_res.cmd;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_cmd, r_right, r_left};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready))
        else $error("input blocked without a stalled output");

    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_tvalid)
        else $error("stepped sample produced no result word");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_prev == $past(r_s1_line)))
        else $error("previous position not updated on step");

endmodule

`default_nettype wire

### hw/rtl/ltd_marks.sv
// Color debounce, mark sequence store and 3-mark command recognizer.
// Depends on ltd_pkg; state advances once per sample the step stage hands to the output stage.
`timescale 1ns / 1ps
`default_nettype none

module ltd_marks import ltd_pkg::*; #(
    parameter int MARK_DEPTH = DEF_MARK_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire logic [3:0] i_color,
    input  wire t_mark_cfg i_cfg,
    output t_mark_res      o_res
);

    localparam int CW = $clog2(MARK_DEPTH + 1);
    localparam int IW = $clog2(MARK_DEPTH);

    logic [3:0]    r_last_color;
    logic [7:0]    r_run;
    logic [3:0]    r_last_mark;
    logic [CW-1:0] r_cnt;
    logic [3:0]    r_store [MARK_DEPTH];
    logic          r_rev;

    logic [7:0]    n_run;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] w_cnt_inc;
    logic          w_mark;
    logic          w_bg;
    logic          w_last_bg;
    logic          w_append;
    logic          w_end;
    t_cmd          w_cmd;

    always_comb begin
        if (i_color == r_last_color) begin
            n_run = (r_run == 8'hFF) ? r_run : r_run + 8'd1;
        end else begin
            n_run = 8'd0;
        end
        w_mark    = (n_run > i_cfg.threshold) && (i_color != r_last_mark);
        w_bg      = (i_color == i_cfg.white_code) || (i_color == i_cfg.black_code);
        w_last_bg = (r_last_mark == i_cfg.white_code) || (r_last_mark == i_cfg.black_code);
        w_append  = w_mark && !w_bg;
        w_end     = w_mark && w_bg && !w_last_bg;
        w_cnt_inc = r_cnt + CW'(1);

        n_cnt = r_cnt;
        if (w_append) begin
            n_cnt = (w_cnt_inc >= CW'(MARK_DEPTH)) ? '0 : w_cnt_inc;
        end else if (w_end) begin
            n_cnt = '0;
        end

        w_cmd = CMD_NONE;
        if (w_end && (r_cnt >= CW'(MIN_SEQ_LEN))) begin
            if (r_store[0] == MARK_THREE && r_store[1] == MARK_FOUR
                    && r_store[2] == MARK_FIVE) begin
                w_cmd = CMD_SLOW;
            end
            if (r_store[0] == MARK_FIVE && r_store[1] == MARK_FOUR
                    && r_store[2] == MARK_THREE) begin
                w_cmd = CMD_FAST;
            end
            if (r_store[0] == MARK_FOUR && r_store[1] == MARK_THREE
                    && r_store[2] == MARK_FOUR) begin
                w_cmd = CMD_REV;
            end
        end

        o_res.cmd = w_cmd;
        o_res.rev = r_rev ^ (w_cmd == CMD_REV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_color <= RST_WHITE_CODE;
            r_run        <= 8'd0;
            r_last_mark  <= RST_WHITE_CODE;
            r_cnt        <= '0;
            r_rev        <= 1'b0;
        end else if (i_adv) begin
            r_last_color <= i_color;
            r_run        <= n_run;
            r_cnt        <= n_cnt;
            r_rev        <= o_res.rev;
            if (w_mark) begin
                r_last_mark <= i_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_append) begin
            r_store[r_cnt[IW-1:0]] <= i_color;
        end
    end

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(MARK_DEPTH))
        else $error("mark count out of range");

    a_cmd_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.cmd != CMD_NONE) |=> (r_cnt == '0))
        else $error("sequence end did not clear mark count");

    a_rev_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.cmd == CMD_REV) |=> (r_rev != $past(r_rev)))
        else $error("reverse command did not toggle direction");

endmodule

`default_nettype wire

### sim/ltd_drive_checker.sv
`timescale 1ns / 1ps
// Result checker for line_trace_drive_with_color_marks: watches the register, sensor
// and result channels, predicts each result word and compares it field by field.
// Depends on ltd_pkg.
module ltd_drive_checker import ltd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] line_position, [19:16] color_code
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [15:0] left_speed, [31:16] right_speed,
                                     // [33:32] mark_command
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_words_due
);

    typedef struct {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        t_cmd               mark_command;
    } t_drive_word;

    logic signed [15:0] prop_gain, deriv_gain, base_speed, max_speed, min_speed;
    logic [3:0]         white_code, black_code;
    logic [7:0]         mark_thr;

    logic [3:0]  last_color, last_mark;
    logic [7:0]  run_length;
    int          mark_count;
    logic [3:0]  mark_store [DEF_MARK_DEPTH];
    longint      prev_position;
    logic        reversed;

    t_drive_word drive_due [$];
    int          mismatch_total = 0;

    function automatic bit is_backdrop(logic [3:0] c);
        return c == white_code || c == black_code;
    endfunction

    function automatic bit store_starts_with(logic [3:0] a, logic [3:0] b, logic [3:0] c);
        return mark_store[0] == a && mark_store[1] == b && mark_store[2] == c;
    endfunction

    // exact Q8.8 product, floor shift
    function automatic longint q88_product(longint a, longint b);
        return (a * b) >>> 8;
    endfunction

    function automatic logic signed [15:0] clamp_speed(longint v);
        if (v > longint'(max_speed)) return max_speed;
        if (v < longint'(min_speed)) return min_speed;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] negate_speed(logic signed [15:0] v);
        if (v == 16'sh8000) return 16'sh7FFF;
        return -v;
    endfunction

    function automatic t_drive_word step_drive(logic signed [15:0] line, logic [3:0] color);
        t_drive_word        w;
        longint             lpos, d, vl, vr;
        logic signed [15:0] cl, cr;
        w.mark_command = CMD_NONE;

        if (color == last_color) begin
            if (run_length != 8'hFF) run_length++;
        end else begin
            run_length = '0;
        end
        last_color = color;

        if (run_length > mark_thr && color != last_mark) begin
            if (!is_backdrop(color)) begin
                if (mark_count < DEF_MARK_DEPTH) mark_store[mark_count] = color;
                mark_count++;
                if (mark_count >= DEF_MARK_DEPTH) mark_count = 0;
            end
            if (is_backdrop(color) && !is_backdrop(last_mark)) begin
                if (mark_count >= MIN_SEQ_LEN) begin
                    if (store_starts_with(MARK_THREE, MARK_FOUR, MARK_FIVE))
                        w.mark_command = CMD_SLOW;
                    if (store_starts_with(MARK_FIVE, MARK_FOUR, MARK_THREE))
                        w.mark_command = CMD_FAST;
                    if (store_starts_with(MARK_FOUR, MARK_THREE, MARK_FOUR)) begin
                        w.mark_command = CMD_REV;
                        reversed = !reversed;
                    end
                end
                mark_count = 0;
            end
            last_mark = color;
        end

        lpos = line;
        d = lpos - prev_position;
        prev_position = lpos;

        vl = base_speed;
        vr = base_speed;
        // below the seek limit neither wheel gets the proportional term
        if (line >= SEEK_LIMIT) begin
            if (line > 0) begin
                vr = base_speed - q88_product(prop_gain, lpos);
            end else if (line < 0) begin
                vl = base_speed + q88_product(prop_gain, lpos);
            end
        end
        vl += q88_product(d, deriv_gain);
        vr += q88_product(d, deriv_gain);
        cl = clamp_speed(vl);
        cr = clamp_speed(vr);

        if (reversed) begin
            w.left_speed  = negate_speed(cr);
            w.right_speed = negate_speed(cl);
        end else begin
            w.left_speed  = cl;
            w.right_speed = cr;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive_word seen;
        t_drive_word want;
        if (!i_rst_n) begin
            prop_gain     = RST_PROP_GAIN;
            deriv_gain    = RST_DERIV_GAIN;
            base_speed    = RST_BASE_SPEED;
            max_speed     = RST_MAX_SPEED;
            min_speed     = RST_MIN_SPEED;
            white_code    = RST_WHITE_CODE;
            black_code    = RST_BLACK_CODE;
            mark_thr      = RST_MARK_THR;
            last_color    = RST_WHITE_CODE;
            last_mark     = RST_WHITE_CODE;
            run_length    = '0;
            mark_count    = 0;
            prev_position = 0;
            reversed      = 1'b0;
            foreach (mark_store[i]) mark_store[i] = '0;
            drive_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:  prop_gain  = i_cfg_data;
                    CFG_DERIV_GAIN: deriv_gain = i_cfg_data;
                    CFG_BASE_SPEED: base_speed = i_cfg_data;
                    CFG_MAX_SPEED:  max_speed  = i_cfg_data;
                    CFG_MIN_SPEED:  min_speed  = i_cfg_data;
                    CFG_WHITE_CODE: white_code = i_cfg_data[3:0];
                    CFG_BLACK_CODE: black_code = i_cfg_data[3:0];
                    CFG_MARK_THR:   mark_thr   = i_cfg_data[7:0];
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                seen.left_speed   = i_m_tdata[15:0];
                seen.right_speed  = i_m_tdata[31:16];
                seen.mark_command = t_cmd'(i_m_tdata[33:32]);
                if (drive_due.size() == 0) begin
                    $error("unexpected result word: left %0d right %0d cmd %0d",
                           seen.left_speed, seen.right_speed, seen.mark_command);
                    mismatch_total++;
                end else begin
                    want = drive_due.pop_front();
                    if (seen.left_speed !== want.left_speed) begin
                        $error("left_speed: expected %0d, got %0d",
                               want.left_speed, seen.left_speed);
                        mismatch_total++;
                    end
                    if (seen.right_speed !== want.right_speed) begin
                        $error("right_speed: expected %0d, got %0d",
                               want.right_speed, seen.right_speed);
                        mismatch_total++;
                    end
                    if (seen.mark_command !== want.mark_command) begin
                        $error("mark_command: expected %0d, got %0d",
                               want.mark_command, seen.mark_command);
                        mismatch_total++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready)
                drive_due.push_back(step_drive(i_s_tdata[15:0], i_s_tdata[19:16]));
        end
        o_mismatches <= mismatch_total;
        o_words_due  <= drive_due.size();
    end

endmodule

### sim/line_trace_drive_with_color_marks_test.sv
`timescale 1ns / 1ps
// Testbench top for line_trace_drive_with_color_marks: clock, reset, register
// settings, sensor words with colour-mark sequences, result back-pressure, verdict.
// Depends on ltd_pkg, the block and ltd_drive_checker.
module line_trace_drive_with_color_marks_test;
    import ltd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    localparam logic signed [15:0] CORNER_POS [10] = '{
        16'sh8000, 16'sd32767, 16'sd0, -16'sd1280, -16'sd1281,
        -16'sd1, 16'sd1, 16'sd256, -16'sd256, 16'sd1281
    };

    // slow, fast and reverse marks, then two colours above the normal range
    localparam logic [3:0] OPENING_COLORS [26] = '{
        MARK_THREE, MARK_THREE, MARK_FOUR, MARK_FOUR, MARK_FIVE, MARK_FIVE,
        RST_WHITE_CODE, RST_WHITE_CODE,
        MARK_FIVE, MARK_FIVE, MARK_FOUR, MARK_FOUR, MARK_THREE, MARK_THREE,
        RST_BLACK_CODE, RST_BLACK_CODE,
        MARK_FOUR, MARK_FOUR, MARK_THREE, MARK_THREE, MARK_FOUR, MARK_FOUR,
        RST_WHITE_CODE, RST_WHITE_CODE,
        4'd15, 4'd10
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int mismatches;
    int words_due;
    int cycle_count = 0;
    int phase_items = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_request = 1'b0;

    logic [3:0] cur_white = RST_WHITE_CODE;
    logic [3:0] cur_black = RST_BLACK_CODE;
    logic [7:0] cur_thr = RST_MARK_THR;

    always #6 clk = ~clk;

    line_trace_drive_with_color_marks i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ltd_drive_checker drive_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("line_trace_drive_with_color_marks_test: errors");
            $finish;
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !rx_idle_on || $urandom_range(0, 99) >= 37;
        end
    end

    task automatic write_register(t_cfg_idx idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_settings(logic signed [15:0] prop, logic signed [15:0] deriv,
                                    logic signed [15:0] base, logic signed [15:0] top,
                                    logic signed [15:0] bottom, logic [3:0] white,
                                    logic [3:0] black, logic [7:0] thr);
        write_register(CFG_PROP_GAIN, prop);
        write_register(CFG_DERIV_GAIN, deriv);
        write_register(CFG_BASE_SPEED, base);
        write_register(CFG_MAX_SPEED, top);
        write_register(CFG_MIN_SPEED, bottom);
        write_register(CFG_WHITE_CODE, {12'd0, white});
        write_register(CFG_BLACK_CODE, {12'd0, black});
        write_register(CFG_MARK_THR, {8'd0, thr});
        cfg_valid <= 1'b0;
        cur_white = white;
        cur_black = black;
        cur_thr   = thr;
    endtask

    task automatic send_sample(logic signed [15:0] pos, logic [3:0] color);
        while (tx_idle_on && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, color, pos};
        do @(posedge clk); while (!s_tready);
        phase_items++;
    endtask

    function automatic logic signed [15:0] pick_position();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return CORNER_POS[$urandom_range(0, 9)];
            default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
    endfunction

    function automatic logic [3:0] pick_backdrop();
        return $urandom_range(0, 1) ? cur_white : cur_black;
    endfunction

    task automatic send_color_run(logic [3:0] color, int len);
        repeat (len) send_sample(pick_position(), color);
    endtask

    // background, a run of marks (known pattern or random), background again
    task automatic send_mark_sequence();
        logic [3:0] marks [$];
        logic [3:0] c;
        int         stable, kind, extra, run;
        stable = int'(cur_thr) + 2;
        kind = $urandom_range(0, 4);
        case (kind)
            0:       marks = {MARK_THREE, MARK_FOUR, MARK_FIVE};
            1:       marks = {MARK_FIVE, MARK_FOUR, MARK_THREE};
            2:       marks = {MARK_FOUR, MARK_THREE, MARK_FOUR};
            default: marks.delete();
        endcase
        if (kind > 2) extra = $urandom_range(3, 12);
        else extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) begin
            do c = 4'($urandom_range(0, 15));
            while (c == cur_white || c == cur_black || (marks.size() > 0 && c == marks[$]));
            marks.push_back(c);
        end
        send_color_run(pick_backdrop(), stable + $urandom_range(0, 2));
        foreach (marks[i]) begin
            run = stable + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) run = $urandom_range(1, stable);
            send_color_run(marks[i], run);
        end
        send_color_run(pick_backdrop(), stable + $urandom_range(0, 2));
    endtask

    task automatic run_phase(int budget, bit with_sequences);
        phase_items = 0;
        while (phase_items < budget) begin
            if (with_sequences && $urandom_range(0, 3) != 0) send_mark_sequence();
            else send_sample(16'($urandom), 4'($urandom_range(0, 15)));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        repeat (2) @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_settings(RST_PROP_GAIN, RST_DERIV_GAIN, RST_BASE_SPEED, RST_MAX_SPEED,
                         RST_MIN_SPEED, RST_WHITE_CODE, RST_BLACK_CODE, 8'd0);
        for (int k = 0; k < 26; k++) send_sample(CORNER_POS[k % 10], OPENING_COLORS[k]);
        s_tvalid <= 1'b0;
        drain_results();

        program_settings(16'sd384, 16'sd128, 16'sd100, 16'sd600, -16'sd600,
                         4'd0, 4'd1, 8'd1);
        run_phase(100, 1'b1);
        drain_results();

        // long stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        program_settings(16'sd32767, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000,
                         4'd2, 4'd7, 8'd0);
        run_phase(90, 1'b1);
        drain_results();

        // crossed limits, white equal to black, receiver holds off
        rx_idle_on = 1'b1;
        program_settings(16'sh8000, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767,
                         4'd9, 4'd9, 8'd2);
        rx_hold_request = 1'b1;
        run_phase(90, 1'b1);
        drain_results();

        tx_idle_on = 1'b1;
        program_settings(16'($urandom_range(0, 1024)) - 16'sd512,
                         16'($urandom_range(0, 1024)) - 16'sd512,
                         16'($urandom_range(0, 512)),
                         16'($urandom_range(0, 20000)),
                         16'(-int'($urandom_range(0, 20000))),
                         4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                         8'($urandom_range(0, 3)));
        run_phase(100, 1'b1);
        drain_results();

        program_settings(RST_PROP_GAIN, RST_DERIV_GAIN, RST_BASE_SPEED, RST_MAX_SPEED,
                         RST_MIN_SPEED, RST_WHITE_CODE, RST_BLACK_CODE, 8'd255);
        run_phase(40, 1'b0);
        drain_results();

        program_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 4'd0, 4'd1, 8'd0);
        run_phase(100, 1'b1);
        drain_results();

        if (mismatches == 0) begin
            $display("line_trace_drive_with_color_marks_test: clean");
        end else begin
            $display("line_trace_drive_with_color_marks_test: errors");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ltd_pkg.sv
hw/rtl/ltd_marks.sv
hw/rtl/line_trace_drive_with_color_marks.sv
sim/ltd_drive_checker.sv
sim/line_trace_drive_with_color_marks_test.sv
